### hw/rtl/modular_exponentiation_64_unit_assert.svh
// Assertion macros used by the modular exponentiation controller.
`ifndef MODULAR_EXPONENTIATION_64_UNIT_ASSERT_SVH
`define MODULAR_EXPONENTIATION_64_UNIT_ASSERT_SVH

// Same-cycle implication, sampled on clk, off during rst.
`define MEXP_ASSERT_IMP(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, sampled on clk, off during rst.
`define MEXP_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

### hw/rtl/mexp_pkg.sv
// Shared types and constants of the modular exponentiation block.
package mexp_pkg;

  localparam int WORD_W      = 64;
  localparam int BYTE_W      = 8;
  localparam int WORD_BYTES  = WORD_W / BYTE_W;
  localparam int COUNT_W     = 4;
  localparam int CFG_INDEX_W = 2;

  localparam logic [BYTE_W-1:0] BYTE_MASK = 8'hFF;

  // Configuration register indexes
  localparam logic [CFG_INDEX_W-1:0] CFG_MODULUS  = 2'd0;
  localparam logic [CFG_INDEX_W-1:0] CFG_EXPONENT = 2'd1;

  typedef logic [WORD_W-1:0] word_t;

  // Commands from the controller to the datapath
  typedef struct packed {
    logic load;
    logic start_reduce;
    logic start_step;
    logic reduce_update;
    logic step_update;
    logic out_load;
  } mexp_cmd_t;

  // Status from the datapath to the controller
  typedef struct packed {
    logic mul_done;
    logic mul_busy;
    logic exp_zero;
  } mexp_status_t;

endpackage

### hw/rtl/mexp_modmul.sv
// Bit-serial modular multiplier: one multiplier bit per cycle, MSB first.
module mexp_modmul import mexp_pkg::*; (
  input  logic  clk,
  input  logic  rst,
  input  logic  start,
  input  word_t a_in,
  input  word_t b_in,
  input  word_t modulus,
  output logic  busy,
  output logic  done,
  output word_t product
);

  localparam int STEPS  = WORD_W;
  localparam int CNT_W  = $clog2(STEPS);

  logic             running;
  logic             done_q;
  logic [CNT_W-1:0] cnt;
  word_t            aop;
  word_t            bsh;
  word_t            r;

  logic [WORD_W+1:0] sum;
  logic [WORD_W+2:0] diff1;
  logic [WORD_W+2:0] diff2;
  word_t             r_next;

  // Double, add the multiplicand on a set bit, then reduce by m or 2m
  always_comb begin
    sum   = {1'b0, r, 1'b0} + {2'b00, (bsh[WORD_W-1] ? aop : '0)};
    diff1 = {1'b0, sum} - {3'b000, modulus};
    diff2 = {1'b0, sum} - {2'b00, modulus, 1'b0};
    if (modulus == '0) begin
      r_next = sum[WORD_W-1:0];
    end else if (!diff2[WORD_W+2]) begin
      r_next = diff2[WORD_W-1:0];
    end else if (!diff1[WORD_W+2]) begin
      r_next = diff1[WORD_W-1:0];
    end else begin
      r_next = sum[WORD_W-1:0];
    end
  end

  // Sequence the steps of one product
  always_ff @(posedge clk) begin
    if (rst) begin
      running <= 1'b0;
      done_q  <= 1'b0;
      cnt     <= '0;
    end else begin
      done_q <= 1'b0;
      if (start && !running) begin
        running <= 1'b1;
        cnt     <= '0;
      end else if (running) begin
        cnt <= cnt + 1'b1;
        if (cnt == CNT_W'(STEPS - 1)) begin
          running <= 1'b0;
          done_q  <= 1'b1;
        end
      end
    end
  end

  // Hold operands and partial remainder
  always_ff @(posedge clk) begin
    if (start && !running) begin
      aop <= a_in;
      bsh <= b_in;
      r   <= '0;
    end else if (running) begin
      bsh <= {bsh[WORD_W-2:0], 1'b0};
      r   <= r_next;
    end
  end

  assign busy    = running;
  assign done    = done_q;
  // Everything is zero modulo one
  assign product = (modulus == word_t'(1)) ? '0 : r;

endmodule

### hw/rtl/mexp_datapath.sv
// Datapath: configuration registers, operands, two multipliers and the result register.
module mexp_datapath import mexp_pkg::*; #(
  parameter int MAX_BYTES = 8
) (
  input  logic                   clk,
  input  logic                   rst,
  input  logic                   cfg_write,
  input  logic [CFG_INDEX_W-1:0] cfg_index,
  input  word_t                  cfg_data,
  input  word_t                  cipher_value,
  input  logic [COUNT_W-1:0]     byte_count,
  input  mexp_cmd_t              cmd,
  output mexp_status_t           status,
  output word_t                  message_value
);

  word_t modulus;
  word_t exponent_cfg;
  word_t base;
  word_t acc;
  word_t expo;
  word_t mask;
  word_t result;

  logic [COUNT_W-1:0] nbytes;
  word_t              mask_in;
  word_t              sq_a;
  word_t              sq_b;
  word_t              sq_prod;
  word_t              acc_prod;
  logic               sq_busy;
  logic               sq_done;
  logic               acc_busy;
  logic               acc_done;

  // Configuration registers
  always_ff @(posedge clk) begin
    if (rst) begin
      modulus      <= word_t'(1);
      exponent_cfg <= '0;
    end else if (cfg_write) begin
      case (cfg_index)
        CFG_MODULUS:  modulus      <= cfg_data;
        CFG_EXPONENT: exponent_cfg <= cfg_data;
        default:      ;
      endcase
    end
  end

  // Saturate the byte count and build the byte mask
  always_comb begin
    nbytes = (byte_count > COUNT_W'(MAX_BYTES)) ? COUNT_W'(MAX_BYTES) : byte_count;
    for (int k = 0; k < WORD_BYTES; k++) begin
      mask_in[k*BYTE_W +: BYTE_W] = (COUNT_W'(k) < nbytes) ? BYTE_MASK : '0;
    end
  end

  // Reduction pass computes 1 * base mod m; steps square the base
  assign sq_a = cmd.start_reduce ? word_t'(1) : base;
  assign sq_b = base;

  mexp_modmul u_sq (
    .clk     (clk),
    .rst     (rst),
    .start   (cmd.start_reduce | cmd.start_step),
    .a_in    (sq_a),
    .b_in    (sq_b),
    .modulus (modulus),
    .busy    (sq_busy),
    .done    (sq_done),
    .product (sq_prod)
  );

  mexp_modmul u_acc (
    .clk     (clk),
    .rst     (rst),
    .start   (cmd.start_step),
    .a_in    (acc),
    .b_in    (base),
    .modulus (modulus),
    .busy    (acc_busy),
    .done    (acc_done),
    .product (acc_prod)
  );

  // Operand registers
  always_ff @(posedge clk) begin
    if (cmd.load) begin
      base <= cipher_value & mask_in;
      mask <= mask_in;
      acc  <= word_t'(1);
      expo <= exponent_cfg;
    end else if (cmd.reduce_update) begin
      base <= sq_prod;
    end else if (cmd.step_update) begin
      base <= sq_prod;
      if (expo[0]) begin
        acc <= acc_prod;
      end
      expo <= {1'b0, expo[WORD_W-1:1]};
    end
  end

  // Result register
  always_ff @(posedge clk) begin
    if (cmd.out_load) begin
      result <= acc & mask;
    end
  end

  assign status.mul_done = sq_done & (acc_done | !acc_busy);
  assign status.mul_busy = sq_busy | acc_busy;
  assign status.exp_zero = (expo == '0);
  assign message_value   = result;

endmodule

### hw/rtl/mexp_ctrl.sv
// Controller: sequences reduction, square-and-multiply steps and the output transfer.
`include "modular_exponentiation_64_unit_assert.svh"

module mexp_ctrl import mexp_pkg::*; (
  input  logic         clk,
  input  logic         rst,
  input  logic         in_valid,
  output logic         in_stall,
  output logic         out_valid,
  input  logic         out_stall,
  input  mexp_status_t status,
  output mexp_cmd_t    cmd
);

  localparam logic [2:0] ST_IDLE        = 3'd0;
  localparam logic [2:0] ST_REDUCE      = 3'd1;
  localparam logic [2:0] ST_REDUCE_WAIT = 3'd2;
  localparam logic [2:0] ST_CHECK       = 3'd3;
  localparam logic [2:0] ST_STEP_WAIT   = 3'd4;
  localparam logic [2:0] ST_DONE        = 3'd5;

  logic [2:0] state;
  logic [2:0] state_next;
  logic       out_valid_next;
  logic       accept;

  assign in_stall = (state != ST_IDLE);
  assign accept   = in_valid && !in_stall;

  // Next state and commands
  always_comb begin
    state_next = state;
    cmd        = '0;
    case (state)
      ST_IDLE: begin
        if (accept) begin
          cmd.load   = 1'b1;
          state_next = ST_REDUCE;
        end
      end
      ST_REDUCE: begin
        cmd.start_reduce = 1'b1;
        state_next       = ST_REDUCE_WAIT;
      end
      ST_REDUCE_WAIT: begin
        if (status.mul_done) begin
          cmd.reduce_update = 1'b1;
          state_next        = ST_CHECK;
        end
      end
      ST_CHECK: begin
        if (status.exp_zero) begin
          state_next = ST_DONE;
        end else begin
          cmd.start_step = 1'b1;
          state_next     = ST_STEP_WAIT;
        end
      end
      ST_STEP_WAIT: begin
        if (status.mul_done) begin
          cmd.step_update = 1'b1;
          state_next      = ST_CHECK;
        end
      end
      ST_DONE: begin
        if (!out_valid || !out_stall) begin
          cmd.out_load = 1'b1;
          state_next   = ST_IDLE;
        end
      end
      default: state_next = ST_IDLE;
    endcase
  end

  // Raise valid on a result load, drop it after the transfer
  always_comb begin
    out_valid_next = out_valid;
    if (cmd.out_load) begin
      out_valid_next = 1'b1;
    end else if (out_valid && !out_stall) begin
      out_valid_next = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= ST_IDLE;
      out_valid <= 1'b0;
    end else begin
      state     <= state_next;
      out_valid <= out_valid_next;
    end
  end

  `MEXP_ASSERT_NEXT(a_accept_busy, accept, state != ST_IDLE, "accepted item left controller idle")
  `MEXP_ASSERT_IMP(a_start_free, cmd.start_reduce || cmd.start_step, !status.mul_busy, "multiplier started while busy")
  `MEXP_ASSERT_IMP(a_valid_from_done, $rose(out_valid), $past(state) == ST_DONE, "result valid without finished item")
  `MEXP_ASSERT_NEXT(a_step_return, (state == ST_STEP_WAIT) && status.mul_done, state == ST_CHECK, "step did not return to check")

endmodule

### hw/rtl/modular_exponentiation_64_unit.sv
// Top level of the 64-bit modular exponentiation block.
//
// Computes message = cipher^d mod n by right-to-left square-and-multiply.
// Input channel (in_valid / in_stall) carries cipher_value and byte_count;
// the value is masked to the low byte_count bytes (counts above MAX_BYTES
// saturate) and the result is masked the same way.
// Configuration channel (cfg_valid / cfg_ready, cfg_index, cfg_data):
// index 0 writes the modulus, index 1 the private exponent. Write only
// while no item is in flight. A modulus of zero means arithmetic mod 2^64.
// Output channel (out_valid / out_stall) carries message_value; one result
// per input item, held in an output register until transferred.
// The work is a reduction of the base, then one multiplier pass per
// exponent bit up to the highest set bit, with the square and the
// multiply running side by side on two bit-serial modular multipliers.
// One item is in work at a time; in_stall is high from transfer to result
// load. A stalled result blocks only the load of the next result.
// Reset (rst, synchronous) clears control state and sets modulus to 1 and
// exponent to 0.
module modular_exponentiation_64_unit import mexp_pkg::*; #(
  parameter int MAX_BYTES = 8
) (
  input  logic                   clk,
  input  logic                   rst,
  input  logic                   in_valid,
  output logic                   in_stall,
  input  logic [WORD_W-1:0]      cipher_value,
  input  logic [COUNT_W-1:0]     byte_count,
  output logic                   out_valid,
  input  logic                   out_stall,
  output logic [WORD_W-1:0]      message_value,
  input  logic                   cfg_valid,
  output logic                   cfg_ready,
  input  logic [CFG_INDEX_W-1:0] cfg_index,
  input  logic [WORD_W-1:0]      cfg_data
);

  mexp_cmd_t    cmd;
  mexp_status_t status;

  // Registers take a write in any cycle
  assign cfg_ready = 1'b1;

  mexp_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .status    (status),
    .cmd       (cmd)
  );

  mexp_datapath #(
    .MAX_BYTES (MAX_BYTES)
  ) u_datapath (
    .clk           (clk),
    .rst           (rst),
    .cfg_write     (cfg_valid & cfg_ready),
    .cfg_index     (cfg_index),
    .cfg_data      (cfg_data),
    .cipher_value  (cipher_value),
    .byte_count    (byte_count),
    .cmd           (cmd),
    .status        (status),
    .message_value (message_value)
  );

endmodule
